[hw/rtl/elft_pkg.sv]
// ----------------------------------------------------------------------------
// elft_pkg
// Shared widths and codes for the exact LRU frame tracker.
// ----------------------------------------------------------------------------
package elft_pkg;

	localparam int FRAME_W = 8;
	localparam int STATUS_W = 2;
	localparam int FRAME_SPACE = 2 ** FRAME_W;

	typedef enum logic {
		CMD_REFERENCE = 1'b0,
		CMD_EVICT     = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_REF_DONE = 2'd0,
		STATUS_VICTIM   = 2'd1,
		STATUS_EMPTY    = 2'd2
	} status_t;

endpackage

[hw/rtl/exact_lru_frame_tracker_core.sv]
// ----------------------------------------------------------------------------
// exact_lru_frame_tracker_core
// Exact LRU order over physical frames, kept as a circular doubly linked list.
//
// A reference beat (tuser = 0) moves the frame in tdata to the most recent
// place and inserts it if it is not resident; an evict beat (tuser = 1) unlinks
// the least recent frame and returns it, or reports an empty list. Links live
// in two memories with one read and one write port each and a registered
// read. One beat is worked on at a time; from the accepting cycle to the
// cycle that loads the output register it passes through these steps:
// accept, read the tail and the frame's links, decide, up to three writes
// on the link memories (WR1, WR2, WR3), and hand-off to the output register.
// Moving a resident frame from the middle of the list uses WR1, WR2 and WR3,
// inserting a frame that is not resident uses WR2 and WR3, and evicting from
// a list of more than one entry uses WR1 only; a hit on the head or the
// tail, an ignored frame number, an evict of the last entry and an evict on
// an empty list use none. The hand-off waits while the previous result is
// still held on the output, so a stalled output adds its stall to the beat.
// The next beat is accepted while a result still waits on the output.
// ----------------------------------------------------------------------------
module exact_lru_frame_tracker_core
	import elft_pkg::*;
#(
	parameter int unsigned NUM_FRAMES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] frame_number
	input  logic       s_tuser,   // [0] command
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] victim_frame
	output logic [1:0] m_tuser    // [1:0] status
);

	localparam int DEPTH = (NUM_FRAMES < FRAME_SPACE) ? int'(NUM_FRAMES) : FRAME_SPACE;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DECIDE,
		ST_WR1,
		ST_WR2,
		ST_WR3,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [AW-1:0] next_mem [DEPTH];
	logic [AW-1:0] prev_mem [DEPTH];
	logic [AW-1:0] next_rdata_q;
	logic [AW-1:0] prev_rdata_q;
	logic [AW-1:0] next_raddr;
	logic [AW-1:0] prev_raddr;
	logic          next_we;
	logic [AW-1:0] next_waddr;
	logic [AW-1:0] next_wdata;
	logic          prev_we;
	logic [AW-1:0] prev_waddr;
	logic [AW-1:0] prev_wdata;

	logic [DEPTH-1:0] resident_q;
	logic [AW-1:0]    head_q;
	logic [CW-1:0]    count_q;

	cmd_t          cmd_q;
	logic          range_ok_q;
	logic [AW-1:0] f_q;
	logic [AW-1:0] h_q;
	logic [AW-1:0] t_q;
	logic [AW-1:0] n_q;
	logic [AW-1:0] p_q;
	status_t       res_status_q;
	logic [7:0]    res_victim_q;

	logic s_beat;
	logic s_range_ok;
	logic out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign s_beat = s_tvalid && s_tready;
	assign s_range_ok = ({24'd0, s_tdata} < 32'(NUM_FRAMES));
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		if (state_q == ST_IDLE) begin
			prev_raddr = head_q;
			next_raddr = s_tdata[AW-1:0];
		end else begin
			prev_raddr = (cmd_q == CMD_EVICT) ? prev_rdata_q : f_q;
			next_raddr = f_q;
		end
	end

	always_comb begin
		next_we = 1'b0;
		prev_we = 1'b0;
		next_waddr = p_q;
		next_wdata = n_q;
		prev_waddr = n_q;
		prev_wdata = p_q;
		case (state_q)
			ST_WR1: begin
				next_we = 1'b1;
				prev_we = 1'b1;
			end
			ST_WR2: begin
				next_we = 1'b1;
				prev_we = 1'b1;
				next_waddr = f_q;
				next_wdata = h_q;
				prev_waddr = f_q;
				prev_wdata = t_q;
			end
			ST_WR3: begin
				next_we = 1'b1;
				prev_we = 1'b1;
				next_waddr = t_q;
				next_wdata = f_q;
				prev_waddr = h_q;
				prev_wdata = f_q;
			end
			default: begin
				next_we = 1'b0;
				prev_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_waddr] <= next_wdata;
		end
		next_rdata_q <= next_mem[next_raddr];
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_waddr] <= prev_wdata;
		end
		prev_rdata_q <= prev_mem[prev_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			resident_q <= '0;
			head_q <= '0;
			count_q <= '0;
			cmd_q <= CMD_REFERENCE;
			range_ok_q <= 1'b0;
			f_q <= '0;
			h_q <= '0;
			t_q <= '0;
			n_q <= '0;
			p_q <= '0;
			res_status_q <= STATUS_REF_DONE;
			res_victim_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			m_tuser <= '0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				m_tvalid <= 1'b1;
				m_tdata <= res_victim_q;
				m_tuser <= res_status_q;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_beat) begin
						cmd_q <= cmd_t'(s_tuser);
						f_q <= s_tdata[AW-1:0];
						range_ok_q <= s_range_ok;
						h_q <= head_q;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					t_q <= prev_rdata_q;
					n_q <= next_rdata_q;
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (cmd_q == CMD_REFERENCE) begin
						res_status_q <= STATUS_REF_DONE;
						res_victim_q <= '0;
						if (!range_ok_q) begin
							state_q <= ST_FIN;
						end else if (!resident_q[f_q]) begin
							resident_q[f_q] <= 1'b1;
							count_q <= count_q + CW'(1);
							head_q <= f_q;
							if (count_q == '0) begin
								h_q <= f_q;
								t_q <= f_q;
							end
							state_q <= ST_WR2;
						end else if (f_q == h_q) begin
							state_q <= ST_FIN;
						end else if (f_q == t_q) begin
							head_q <= f_q;
							state_q <= ST_FIN;
						end else begin
							p_q <= prev_rdata_q;
							head_q <= f_q;
							state_q <= ST_WR1;
						end
					end else if (count_q == '0) begin
						res_status_q <= STATUS_EMPTY;
						res_victim_q <= '0;
						state_q <= ST_FIN;
					end else begin
						res_status_q <= STATUS_VICTIM;
						res_victim_q <= 8'(t_q);
						resident_q[t_q] <= 1'b0;
						count_q <= count_q - CW'(1);
						if (count_q != CW'(1)) begin
							p_q <= prev_rdata_q;
							n_q <= h_q;
							state_q <= ST_WR1;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_WR1: begin
					state_q <= (cmd_q == CMD_EVICT) ? ST_FIN : ST_WR2;
				end
				ST_WR2: begin
					state_q <= ST_WR3;
				end
				ST_WR3: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/elft_checker.sv]
// ----------------------------------------------------------------------------
// elft_checker
// Port-level checks for the exact LRU frame tracker, bound to the top level.
// ----------------------------------------------------------------------------
module elft_checker
	import elft_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser
);

	// A result beat that is not a victim carries a zero frame.
	a_zero_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != STATUS_VICTIM) |-> (m_tdata == 8'd0))
		else $error("non-victim result carries a nonzero frame");

	// Only the three defined status codes appear.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STATUS_REF_DONE || m_tuser == STATUS_VICTIM ||
			m_tuser == STATUS_EMPTY))
		else $error("undefined status code on the output");

	// One beat is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
		else $error("input accepted while a beat is in work");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result beat changed");

endmodule

bind exact_lru_frame_tracker_core elft_checker u_elft_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for exact_lru_frame_tracker_core.
//
// Reference and evict beats go in on the slave side. A behavioral copy of the
// recency list predicts the status and victim for every accepted beat, and
// each result beat is checked against the oldest prediction. Directed cases
// cover the empty list, the one-entry list, head, tail and middle hits and
// the extreme frame numbers. Random phases then work a small hot set, the
// whole frame range, and a full fill and drain of all frames. Both sides
// idle at random, and one phase stalls the output long enough to back up
// the input.
// ----------------------------------------------------------------------------
module tb;
	import elft_pkg::*;

	localparam int unsigned FRAMES = 256;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned LONG_HOLD = 150;

	typedef struct packed {
		status_t            status;
		logic [FRAME_W-1:0] victim;
	} lru_result_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [FRAME_W-1:0] s_tdata;
	logic               s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	logic [FRAME_W-1:0] m_tdata;
	logic [1:0]         m_tuser;

	logic [FRAME_W-1:0] next_of [FRAME_SPACE];
	logic [FRAME_W-1:0] prev_of [FRAME_SPACE];
	bit                 resident [FRAME_SPACE];
	logic [FRAME_W-1:0] mru_frame;
	int unsigned        live_frames;

	lru_result_t pending_results [$];
	int unsigned mismatches;
	int unsigned quiet_cycles;
	int unsigned sink_hold_request;
	bit          src_idle;
	bit          sink_idle;

	exact_lru_frame_tracker_core #(
		.NUM_FRAMES(FRAMES)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #10 clk = ~clk;

	function automatic void link_at_mru(logic [FRAME_W-1:0] f);
		logic [FRAME_W-1:0] h;
		logic [FRAME_W-1:0] t;
		h = mru_frame;
		t = prev_of[h];
		next_of[f] = h;
		prev_of[f] = t;
		next_of[t] = f;
		prev_of[h] = f;
		mru_frame = f;
	endfunction

	function automatic lru_result_t lru_apply(cmd_t cmd, logic [FRAME_W-1:0] f);
		lru_result_t        res;
		logic [FRAME_W-1:0] v;
		logic [FRAME_W-1:0] p;
		logic [FRAME_W-1:0] n;
		res.status = STATUS_REF_DONE;
		res.victim = '0;
		if (cmd == CMD_REFERENCE) begin
			if (int'(f) >= FRAMES)
				return res;
			if (!resident[f]) begin
				if (live_frames == 0) begin
					next_of[f] = f;
					prev_of[f] = f;
					mru_frame = f;
				end else begin
					link_at_mru(f);
				end
				resident[f] = 1'b1;
				live_frames++;
			end else if (f != mru_frame) begin
				if (f == prev_of[mru_frame]) begin
					mru_frame = f;
				end else begin
					p = prev_of[f];
					n = next_of[f];
					next_of[p] = n;
					prev_of[n] = p;
					link_at_mru(f);
				end
			end
			return res;
		end
		if (live_frames == 0) begin
			res.status = STATUS_EMPTY;
			return res;
		end
		v = prev_of[mru_frame];
		if (live_frames > 1) begin
			p = prev_of[v];
			next_of[p] = mru_frame;
			prev_of[mru_frame] = p;
		end
		resident[v] = 1'b0;
		live_frames--;
		res.status = STATUS_VICTIM;
		res.victim = v;
		return res;
	endfunction

	task automatic send_beat(cmd_t cmd, logic [FRAME_W-1:0] frame);
		int unsigned gap;
		gap = src_idle ? $urandom_range(0, 5) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= frame;
		do @(posedge clk); while (s_tready !== 1'b1);
		pending_results.push_back(lru_apply(cmd, frame));
	endtask

	function automatic cmd_t draw_cmd(int unsigned evict_percent);
		return ($urandom_range(0, 99) < evict_percent) ? CMD_EVICT : CMD_REFERENCE;
	endfunction

	task automatic test_empty_list();
		send_beat(CMD_EVICT, 8'h00);
		send_beat(CMD_EVICT, 8'hFF);
	endtask

	task automatic test_single_entry();
		send_beat(CMD_REFERENCE, 8'h00);
		send_beat(CMD_REFERENCE, 8'h00);
		send_beat(CMD_EVICT, 8'h00);
		send_beat(CMD_EVICT, 8'h5A);
		send_beat(CMD_REFERENCE, 8'hFF);
		send_beat(CMD_EVICT, 8'h00);
	endtask

	task automatic test_order_cases();
		for (int i = 1; i <= 4; i++)
			send_beat(CMD_REFERENCE, 8'(i));
		send_beat(CMD_REFERENCE, 8'd4);
		send_beat(CMD_REFERENCE, 8'd1);
		send_beat(CMD_REFERENCE, 8'd3);
		send_beat(CMD_REFERENCE, 8'hAA);
		send_beat(CMD_REFERENCE, 8'h55);
		repeat (7) send_beat(CMD_EVICT, 8'hFF);
	endtask

	task automatic test_backpressure();
		logic [FRAME_W-1:0] base;
		base = 8'($urandom_range(0, 255));
		src_idle = 1'b0;
		sink_hold_request = LONG_HOLD;
		repeat (16)
			send_beat(draw_cmd(25), base + 8'($urandom_range(0, 5)));
		src_idle = 1'b1;
	endtask

	task automatic test_hot_set(int unsigned count);
		logic [FRAME_W-1:0] base;
		base = 8'($urandom_range(0, 255));
		for (int unsigned i = 0; i < count; i++) begin
			src_idle = ((i / 60) % 3) != 2;
			sink_idle = ((i / 45) % 3) != 1;
			send_beat(draw_cmd(20), base + 8'($urandom_range(0, 11)));
		end
		src_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	task automatic test_wide_mix(int unsigned count);
		repeat (count)
			send_beat(draw_cmd(30), 8'($urandom_range(0, 255)));
	endtask

	task automatic test_fill_and_drain();
		logic [FRAME_W-1:0] order [FRAME_SPACE];
		logic [FRAME_W-1:0] swap;
		int unsigned        j;
		for (int i = 0; i < FRAME_SPACE; i++)
			order[i] = 8'(i);
		for (int i = FRAME_SPACE - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			swap = order[i];
			order[i] = order[j];
			order[j] = swap;
		end
		src_idle = 1'b0;
		sink_idle = 1'b0;
		for (int i = 0; i < FRAME_SPACE; i++)
			send_beat(CMD_REFERENCE, order[i]);
		src_idle = 1'b1;
		sink_idle = 1'b1;
		repeat (40)
			send_beat(CMD_REFERENCE, 8'($urandom_range(0, 255)));
		repeat (FRAME_SPACE + 4)
			send_beat(CMD_EVICT, 8'($urandom_range(0, 255)));
	endtask

	initial begin : sink
		int unsigned gap;
		gap = 0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_hold_request != 0) begin
				gap = sink_hold_request;
				sink_hold_request = 0;
			end else if (m_tvalid && m_tready) begin
				gap = sink_idle ? $urandom_range(0, 5) : 0;
			end else if (gap != 0) begin
				gap--;
			end
			m_tready <= (gap == 0);
		end
	end

	always @(posedge clk) begin : result_check
		lru_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("unexpected result beat: status %0d victim %0d",
						m_tuser, m_tdata);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status || m_tdata !== want.victim) begin
					if (mismatches < MAX_REPORTS)
						$display("mismatch: expected status %0d victim %0d, got status %0d victim %0d",
							want.status, want.victim, m_tuser, m_tdata);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("exact_lru_frame_tracker_core regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_REFERENCE;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		sink_hold_request = 0;
		mismatches = 0;
		quiet_cycles = 0;
		for (int i = 0; i < FRAME_SPACE; i++) begin
			next_of[i] = '0;
			prev_of[i] = '0;
			resident[i] = 1'b0;
		end
		mru_frame = '0;
		live_frames = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_list();
		test_single_entry();
		test_order_cases();
		test_backpressure();
		test_hot_set(250);
		test_wide_mix(150);
		test_fill_and_drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("exact_lru_frame_tracker_core regression: pass");
		else
			$display("exact_lru_frame_tracker_core regression: fail");
		$finish;
	end

endmodule

[files.f]
hw/rtl/elft_pkg.sv
hw/rtl/exact_lru_frame_tracker_core.sv
hw/rtl/elft_checker.sv
test/tb.sv
